/* rtl/core/gmfc_pkg.sv */
// Shared types and constants for the gate fusion block.
package gmfc_pkg;

  localparam int ID_BITS   = 6;
  localparam int LIST_BITS = 18;
  localparam int MAXQ      = 3;

  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_FUSE   = 2'd2;
  localparam logic [1:0] REQ_NOP    = 2'd3;

  localparam logic [1:0] REG_A_COUNT = 2'd0;
  localparam logic [1:0] REG_B_COUNT = 2'd1;
  localparam logic [1:0] REG_A_LIST  = 2'd2;
  localparam logic [1:0] REG_B_LIST  = 2'd3;

  // Item handed from the front part to the back part through the queue.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [5:0]  elem_index;
    logic [31:0] word;
  } cmd_t;

endpackage

/* rtl/core/gmfc_front.sv */
// Front part: accepts items, drops no-op requests, queues the rest.
module gmfc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [1:0]           req_type,
  input  logic [5:0]           elem_index,
  input  logic signed [15:0]   elem_re,
  input  logic signed [15:0]   elem_im,
  output logic                 busy,
  output gmfc_pkg::cmd_t       cmd,
  output logic                 cmd_valid,
  input  logic                 cmd_take
);
  import gmfc_pkg::*;

  cmd_t       q [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic       push, pop;

  assign busy      = (fill >= 3'd3);
  assign push      = start && !busy && (req_type != REQ_NOP);
  assign cmd_valid = (fill != 3'd0);
  assign pop       = cmd_valid && cmd_take;
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= '{req_type, elem_index, {elem_re, elem_im}};
  end

  property p_no_overflow;
    @(posedge clk) disable iff (rst) fill <= 3'd4;
  endproperty
  assert property (p_no_overflow) else $error("queue overflow");

  property p_pop_nonempty;
    @(posedge clk) disable iff (rst) cmd_take |-> (fill != 3'd0) || !pop;
  endproperty
  assert property (p_pop_nonempty) else $error("pop from empty queue");

  property p_fill_step;
    @(posedge clk) disable iff (rst) (push && !pop) |=> fill == $past(fill) + 3'd1;
  endproperty
  assert property (p_fill_step) else $error("fill count slip");

endmodule

/* rtl/core/gmfc_back.sv */
// Back part: stores elements and walks the products of a fusion run.
module gmfc_back (
  input  logic               clk,
  input  logic               rst,
  input  gmfc_pkg::cmd_t     cmd,
  input  logic               cmd_valid,
  output logic               cmd_take,
  input  logic [1:0]         a_qubit_count,
  input  logic [1:0]         b_qubit_count,
  input  logic [17:0]        a_qubit_list,
  input  logic [17:0]        b_qubit_list,
  output logic               done,
  output logic [5:0]         out_index,
  output logic signed [15:0] out_re,
  output logic signed [15:0] out_im,
  output logic [2:0]         union_count,
  output logic [17:0]        union_list,
  output logic               fuse_error,
  output logic               last_entry,
  output logic               idle
);
  import gmfc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_SORT = 3'd2;
  localparam logic [2:0] S_MAP = 3'd3;
  localparam logic [2:0] S_RUN = 3'd4;
  localparam logic [2:0] S_OUT = 3'd5;

  logic [2:0] state;
  logic [31:0] amem [64];
  logic [31:0] bmem [64];
  logic [31:0] ard, brd;

  logic [1:0] an, bn;
  logic [5:0] uq [6];
  logic [2:0] un;
  logic [2:0] sort_k;
  logic [5:0] acol [3], arow [3], bcol [3], brow [3];
  logic [5:0] sa [3], sb [3];
  logic [1:0] m;
  logic [5:0] ulist_q [3];

  logic [5:0] ent;       // entry index
  logic [3:0] jj;        // shared-product index, one extra bit for wrap
  logic       rd_valid;  // reads in flight for the last issued address
  logic       rd_last;
  logic       prod_v, prod_last;
  logic signed [31:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [40:0] sre, sim;
  logic [5:0] ai, bi;

  // Union building (combinational, six narrow candidates).
  logic [5:0] cand [6];
  logic       cand_ok [6];
  logic [5:0] uq_b [6];
  logic [2:0] un_b;

  function automatic logic [5:0] qat(input logic [17:0] l, input int k);
    return l[k*ID_BITS +: ID_BITS];
  endfunction

  function automatic logic signed [15:0] rsat(input logic signed [40:0] s);
    logic signed [40:0] t;
    logic signed [26:0] q;
    t = s + 41'sd8192;
    q = t[40:14];
    if (q > 27'sd32767) return 16'sh7fff;
    if (q < -27'sd32768) return 16'sh8000;
    return q[15:0];
  endfunction

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      cand[k] = (k < 3) ? qat(b_qubit_list, k) : qat(a_qubit_list, k - 3);
      cand_ok[k] = (k < 3) ? (k < int'(bn)) : ((k - 3) < int'(an));
    end
    un_b = '0;
    for (int k = 0; k < 6; k++) uq_b[k] = '0;
    for (int k = 0; k < 6; k++) begin
      logic seen;
      seen = 1'b0;
      for (int j = 0; j < k; j++)
        if (cand_ok[j] && cand[j] == cand[k]) seen = 1'b1;
      if (cand_ok[k] && !seen) begin
        uq_b[un_b] = cand[k];
        un_b = un_b + 3'd1;
      end
    end
  end

  // Address of current product.
  always_comb begin
    ai = '0;
    bi = '0;
    for (int k = 0; k < 3; k++) begin
      if (k < int'(un)) begin
        if (ent[k]) begin
          ai = ai + acol[k];
          bi = bi + bcol[k];
        end
        if (ent[k + int'(un)]) begin
          ai = ai + arow[k];
          bi = bi + brow[k];
        end
      end
      if (k < int'(m) && jj[k]) begin
        ai = ai + sa[k];
        bi = bi + sb[k];
      end
    end
  end

  logic [5:0] total_m1;
  logic       last_j;
  assign total_m1 = 6'((7'd1 << {un, 1'b0}) - 7'd1);
  assign last_j   = (jj[2:0] == 3'((4'd1 << m) - 4'd1));

  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign idle     = (state == S_IDLE) && !cmd_valid;

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.req_type == REQ_LOAD_A) amem[cmd.elem_index] <= cmd.word;
    if (cmd_take && cmd.req_type == REQ_LOAD_B) bmem[cmd.elem_index] <= cmd.word;
    ard <= amem[ai];
    brd <= bmem[bi];
    p_rr <= $signed(ard[31:16]) * $signed(brd[31:16]);
    p_ii <= $signed(ard[15:0]) * $signed(brd[15:0]);
    p_ri <= $signed(ard[31:16]) * $signed(brd[15:0]);
    p_ir <= $signed(ard[15:0]) * $signed(brd[31:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      done     <= 1'b0;
      rd_valid <= 1'b0;
      prod_v   <= 1'b0;
    end else begin
      done     <= 1'b0;
      prod_v   <= rd_valid;
      prod_last <= rd_last;
      rd_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (cmd_take && cmd.req_type == REQ_FUSE) begin
          an <= (a_qubit_count > 2'd3) ? 2'd3 : a_qubit_count;
          bn <= (b_qubit_count > 2'd3) ? 2'd3 : b_qubit_count;
          state <= S_SETUP;
        end
        S_SETUP: begin
          for (int k = 0; k < 6; k++) uq[k] <= uq_b[k];
          un <= un_b;
          sort_k <= 3'd0;
          if (un_b > 3'd3) begin
            done <= 1'b1; fuse_error <= 1'b1; last_entry <= 1'b1;
            union_count <= un_b; union_list <= '0;
            out_index <= '0; out_re <= '0; out_im <= '0;
            state <= S_IDLE;
          end else state <= S_SORT;
        end
        S_SORT: begin
          // compare-exchange passes over three slots
          if (sort_k[0] == 1'b0) begin
            if (un > 3'd1 && uq[0] > uq[1]) begin uq[0] <= uq[1]; uq[1] <= uq[0]; end
          end else begin
            if (un > 3'd2 && uq[1] > uq[2]) begin uq[1] <= uq[2]; uq[2] <= uq[1]; end
          end
          sort_k <= sort_k + 3'd1;
          if (sort_k == 3'd3) state <= S_MAP;
        end
        S_MAP: begin
          logic [1:0] mm;
          mm = '0;
          for (int k = 0; k < 3; k++) begin
            int ap, bp;
            ap = -1; bp = -1;
            for (int p = 2; p >= 0; p--) begin
              if (p < int'(an) && qat(a_qubit_list, p) == uq[k]) ap = p;
              if (p < int'(bn) && qat(b_qubit_list, p) == uq[k]) bp = p;
            end
            acol[k] <= '0; arow[k] <= '0; bcol[k] <= '0; brow[k] <= '0;
            ulist_q[k] <= (k < int'(un)) ? uq[k] : 6'd0;
            if (k < int'(un)) begin
              if (ap >= 0 && bp >= 0) begin
                bcol[k] <= 6'(1 << bp);
                arow[k] <= 6'(1 << (ap + int'(an)));
                sa[mm] <= 6'(1 << ap);
                sb[mm] <= 6'(1 << (bp + int'(bn)));
                mm = mm + 2'd1;
              end else if (ap >= 0) begin
                acol[k] <= 6'(1 << ap);
                arow[k] <= 6'(1 << (ap + int'(an)));
              end else if (bp >= 0) begin
                bcol[k] <= 6'(1 << bp);
                brow[k] <= 6'(1 << (bp + int'(bn)));
              end
            end
          end
          m <= mm;
          ent <= '0; jj <= '0;
          sre <= '0; sim <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          rd_valid <= 1'b1;
          rd_last  <= last_j;
          if (last_j) begin
            jj <= '0;
            state <= S_OUT;
          end else jj <= jj + 4'd1;
        end
        S_OUT: ;
        default: state <= S_IDLE;
      endcase
      if (prod_v) begin
        if (prod_last) begin
          logic signed [40:0] fr, fi;
          fr = sre + 41'(p_rr) - 41'(p_ii);
          fi = sim + 41'(p_ri) + 41'(p_ir);
          done <= 1'b1; fuse_error <= 1'b0;
          out_index <= ent; out_re <= rsat(fr); out_im <= rsat(fi);
          union_count <= un;
          union_list <= {ulist_q[2], ulist_q[1], ulist_q[0]};
          last_entry <= (ent == total_m1);
          sre <= '0; sim <= '0;
          if (ent == total_m1) state <= S_IDLE;
          else begin
            ent <= ent + 6'd1;
            state <= S_RUN;
          end
        end else begin
          sre <= sre + 41'(p_rr) - 41'(p_ii);
          sim <= sim + 41'(p_ri) + 41'(p_ir);
        end
      end
    end
  end

  property p_done_in_run;
    @(posedge clk) disable iff (rst) (done && !fuse_error) |-> $past(prod_v);
  endproperty
  assert property (p_done_in_run) else $error("entry without products");

  property p_union_small;
    @(posedge clk) disable iff (rst) (state == S_RUN) |-> un <= 3'd3;
  endproperty
  assert property (p_union_small) else $error("run with oversized union");

  property p_last_idle;
    @(posedge clk) disable iff (rst) (done && last_entry) |-> state == S_IDLE;
  endproperty
  assert property (p_last_idle) else $error("last entry but still running");

endmodule

/* rtl/core/gate_matrix_fusion_contract_core.sv */
// Top level of the gate fusion block: config port, front and back parts.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  command   | start / busy         | req_type elem_index elem_re elem_im
//  result    | done (one cycle)     | out_index out_re out_im union_count ...
//  config    | APB psel/penable     | a/b_qubit_count, a/b_qubit_list
//
// Loads pass through a queue that holds up to three items. A fusion run
// gives 4^n entries, n the union size; each entry sums 2^m products, m the
// shared-qubit count, one at a time on the back part's single product path.
// An oversized union gives one error item with fuse_error and last_entry set.
// Reset is synchronous; the stores are not cleared. Results cannot be stalled.
module gate_matrix_fusion_contract_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [5:0]         elem_index,
  input  logic signed [15:0] elem_re,
  input  logic signed [15:0] elem_im,
  output logic               done,
  output logic [5:0]         out_index,
  output logic signed [15:0] out_re,
  output logic signed [15:0] out_im,
  output logic [2:0]         union_count,
  output logic [17:0]        union_list,
  output logic               fuse_error,
  output logic               last_entry,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import gmfc_pkg::*;

  logic [1:0]  a_qubit_count, b_qubit_count;
  logic [17:0] a_qubit_list, b_qubit_list;
  cmd_t        cmd;
  logic        cmd_valid, cmd_take, back_idle;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_qubit_count <= 2'd1;
      b_qubit_count <= 2'd1;
      a_qubit_list  <= '0;
      b_qubit_list  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_A_COUNT: a_qubit_count <= pwdata[1:0];
        REG_B_COUNT: b_qubit_count <= pwdata[1:0];
        REG_A_LIST:  a_qubit_list  <= pwdata[17:0];
        REG_B_LIST:  b_qubit_list  <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_A_COUNT: prdata = {30'b0, a_qubit_count};
      REG_B_COUNT: prdata = {30'b0, b_qubit_count};
      REG_A_LIST:  prdata = {14'b0, a_qubit_list};
      REG_B_LIST:  prdata = {14'b0, b_qubit_list};
      default:     prdata = '0;
    endcase
  end

  gmfc_front u_front (
    .clk, .rst, .start, .req_type, .elem_index, .elem_re, .elem_im,
    .busy, .cmd, .cmd_valid, .cmd_take
  );

  gmfc_back u_back (
    .clk, .rst, .cmd, .cmd_valid, .cmd_take,
    .a_qubit_count, .b_qubit_count, .a_qubit_list, .b_qubit_list,
    .done, .out_index, .out_re, .out_im, .union_count, .union_list,
    .fuse_error, .last_entry, .idle(back_idle)
  );

  property p_error_single;
    @(posedge clk) disable iff (rst) (done && fuse_error) |-> last_entry;
  endproperty
  assert property (p_error_single) else $error("error result not last");

  property p_idle_no_done;
    @(posedge clk) disable iff (rst) (back_idle && $past(back_idle)) |-> !done;
  endproperty
  assert property (p_idle_no_done) else $error("result while idle");

  property p_err_fields;
    @(posedge clk) disable iff (rst) (done && fuse_error) |-> union_count > 3'd3;
  endproperty
  assert property (p_err_fields) else $error("error with small union");

endmodule

/* tb/sv/gate_matrix_fusion_contract_core_tb.sv */
// Testbench for the gate fusion block: random and directed items, scored by a predictor.
`timescale 1ns / 100ps

module gate_matrix_fusion_contract_core_tb;
  import gmfc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = 24;

  typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] re;
    logic [15:0] im;
    logic [2:0]  ucnt;
    logic [17:0] ulist;
    logic        err;
    logic        last;
  } entry_t;

  class fusion_scoreboard;
    bit [31:0] a_mem [64];
    bit [31:0] b_mem [64];
    bit [1:0]  a_cnt = 1;
    bit [1:0]  b_cnt = 1;
    bit [17:0] a_ids = 0;
    bit [17:0] b_ids = 0;
    entry_t    fused_q [$];
    int        errors = 0;

    function void set_reg(logic [1:0] r, bit [31:0] v);
      case (r)
        REG_A_COUNT: a_cnt = v[1:0];
        REG_B_COUNT: b_cnt = v[1:0];
        REG_A_LIST:  a_ids = v[17:0];
        default:     b_ids = v[17:0];
      endcase
    endfunction

    function void add_expected(entry_t e);
      fused_q = {fused_q, e};
    endfunction

    function int pos_of(bit [17:0] ids, int n, int q);
      for (int p = 0; p < n; p++)
        if (int'(ids[p*ID_BITS +: ID_BITS]) == q) return p;
      return -1;
    endfunction

    function bit [15:0] round_sat(longint s);
      longint t;
      t = (s + 64'sd8192) >>> 14;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t[15:0];
    endfunction

    function void add_unique(ref int uq[6], ref int un, input int q);
      for (int j = 0; j < un; j++)
        if (uq[j] == q) return;
      uq[un] = q;
      un++;
    endfunction

    function void fuse();
      int an, bn, un, m, ap, bp, tot, v, j, ax, bx, abase, bbase;
      int uq [6];
      int acol [3], arow [3], bcol [3], brow [3], sa [3], sb [3];
      bit [17:0] ul;
      longint sre, sim, ar, aim, br, bim;
      entry_t e;
      an = int'(a_cnt);
      bn = int'(b_cnt);
      un = 0;
      m = 0;
      ul = '0;
      for (int k = 0; k < bn; k++) add_unique(uq, un, int'(b_ids[k*ID_BITS +: ID_BITS]));
      for (int k = 0; k < an; k++) add_unique(uq, un, int'(a_ids[k*ID_BITS +: ID_BITS]));
      for (int k = 1; k < un; k++) begin
        v = uq[k];
        j = k;
        while (j > 0 && uq[j-1] > v) begin
          uq[j] = uq[j-1];
          j--;
        end
        uq[j] = v;
      end
      if (un > MAXQ) begin
        e = '0;
        e.ucnt = 3'(un);
        e.err = 1'b1;
        e.last = 1'b1;
        add_expected(e);
        return;
      end
      for (int k = 0; k < un; k++) begin
        ap = pos_of(a_ids, an, uq[k]);
        bp = pos_of(b_ids, bn, uq[k]);
        acol[k] = 0; arow[k] = 0; bcol[k] = 0; brow[k] = 0;
        if (ap >= 0 && bp >= 0) begin
          bcol[k] = 1 << bp;
          arow[k] = 1 << (ap + an);
          sa[m] = 1 << ap;
          sb[m] = 1 << (bp + bn);
          m++;
        end else if (ap >= 0) begin
          acol[k] = 1 << ap;
          arow[k] = 1 << (ap + an);
        end else if (bp >= 0) begin
          bcol[k] = 1 << bp;
          brow[k] = 1 << (bp + bn);
        end
        ul[k*ID_BITS +: ID_BITS] = 6'(uq[k]);
      end
      tot = 1 << (2 * un);
      for (int i = 0; i < tot; i++) begin
        abase = 0;
        bbase = 0;
        sre = 0;
        sim = 0;
        for (int k = 0; k < un; k++) begin
          if ((i >> k) & 1) begin
            abase += acol[k];
            bbase += bcol[k];
          end
          if ((i >> (k + un)) & 1) begin
            abase += arow[k];
            bbase += brow[k];
          end
        end
        for (int s = 0; s < (1 << m); s++) begin
          ax = abase;
          bx = bbase;
          for (int k = 0; k < m; k++)
            if ((s >> k) & 1) begin
              ax += sa[k];
              bx += sb[k];
            end
          ar  = $signed(a_mem[ax & 63][31:16]);
          aim = $signed(a_mem[ax & 63][15:0]);
          br  = $signed(b_mem[bx & 63][31:16]);
          bim = $signed(b_mem[bx & 63][15:0]);
          sre += ar * br - aim * bim;
          sim += ar * bim + aim * br;
        end
        e.idx = 6'(i);
        e.re = round_sat(sre);
        e.im = round_sat(sim);
        e.ucnt = 3'(un);
        e.ulist = ul;
        e.err = 1'b0;
        e.last = (i + 1 == tot);
        add_expected(e);
      end
    endfunction

    function void note_item(logic [1:0] kind, logic [5:0] idx, logic [15:0] re,
                            logic [15:0] im);
      case (kind)
        REQ_LOAD_A: a_mem[idx] = {re, im};
        REQ_LOAD_B: b_mem[idx] = {re, im};
        REQ_FUSE:   fuse();
        default: ;
      endcase
    endfunction

    function void fail(string why, entry_t w, entry_t g);
      errors++;
      if (errors <= 10) begin
        $write("%0t %s: exp idx=%0d re=%0d im=%0d ucnt=%0d ulist=%h err=%0d last=%0d",
               $realtime, why, w.idx, $signed(w.re), $signed(w.im), w.ucnt, w.ulist,
               w.err, w.last);
        $display(" | got idx=%0d re=%0d im=%0d ucnt=%0d ulist=%h err=%0d last=%0d",
                 g.idx, $signed(g.re), $signed(g.im), g.ucnt, g.ulist, g.err, g.last);
      end
    endfunction

    function void check_entry(entry_t got);
      entry_t w;
      if (fused_q.size() == 0) begin
        fail("unexpected entry", '0, got);
        return;
      end
      w = fused_q.pop_front();
      if (got.idx !== w.idx || got.re !== w.re || got.im !== w.im || got.ucnt !== w.ucnt ||
          got.ulist !== w.ulist || got.err !== w.err || got.last !== w.last)
        fail("entry mismatch", w, got);
    endfunction
  endclass

  logic               clk, rst, start, busy, done;
  logic [1:0]         req_type;
  logic [5:0]         elem_index;
  logic signed [15:0] elem_re, elem_im;
  logic [5:0]         out_index;
  logic signed [15:0] out_re, out_im;
  logic [2:0]         union_count;
  logic [17:0]        union_list;
  logic               fuse_error, last_entry;
  logic               psel, penable, pwrite, pready;
  logic [3:0]         paddr;
  logic [31:0]        pwdata, prdata;

  fusion_scoreboard sb = new();
  bit  calm;
  int  cycles;

  gate_matrix_fusion_contract_core DUT (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk)
    if (!rst && done)
      sb.check_entry({out_index, out_re, out_im, union_count, union_list, fuse_error,
                      last_entry});

  task write_reg(logic [1:0] r, bit [31:0] v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; paddr <= {r, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.set_reg(r, v);
  endtask

  task set_gates(bit [1:0] ac, bit [1:0] bc, bit [17:0] al, bit [17:0] bl);
    write_reg(REG_A_COUNT, {30'b0, ac});
    write_reg(REG_B_COUNT, {30'b0, bc});
    write_reg(REG_A_LIST, {14'b0, al});
    write_reg(REG_B_LIST, {14'b0, bl});
  endtask

  // Leave start high on return so back-to-back items need no extra edge.
  task send_item(logic [1:0] kind, logic [5:0] idx, logic [15:0] re, logic [15:0] im);
    if (!calm && $urandom_range(0, 99) < 19) begin
      start <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1; req_type <= kind; elem_index <= idx; elem_re <= re; elem_im <= im;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_item(kind, idx, re, im);
  endtask

  task drain_results();
    start <= 0;
    while (sb.fused_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  function bit [17:0] pick_ids();
    bit [17:0] l;
    for (int k = 0; k < 3; k++)
      l[k*6 +: 6] = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63)) :
                                                   6'($urandom_range(0, 5));
    return l;
  endfunction

  task random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 58)
      send_item(r[0] ? REQ_LOAD_B : REQ_LOAD_A, 6'($urandom_range(0, 63)), pick_value(),
                pick_value());
    else if (r < 90)
      send_item(REQ_FUSE, 6'($urandom()), 16'($urandom()), 16'($urandom()));
    else
      send_item(REQ_NOP, 6'($urandom()), 16'($urandom()), 16'($urandom()));
  endtask

  task directed_phase(bit [1:0] ac, bit [1:0] bc, bit [17:0] al, bit [17:0] bl);
    set_gates(ac, bc, al, bl);
    send_item(REQ_LOAD_A, 6'd0, 16'h8000, 16'h7FFF);
    send_item(REQ_FUSE, 6'd0, 16'h0, 16'h0);
    drain_results();
  endtask

  initial begin
    rst = 1; start = 0; req_type = 0; elem_index = 0; elem_re = 0; elem_im = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    calm = 0;
    cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    set_gates(2'd1, 2'd1, 18'd0, 18'd0);

    // Fill both stores so no fusion reads an unwritten entry.
    for (int i = 0; i < 64; i++) begin
      send_item(REQ_LOAD_A, 6'(i), (i == 0) ? 16'h8000 : (i == 63) ? 16'h7FFF : pick_value(),
                (i == 0) ? 16'h7FFF : (i == 63) ? 16'h8000 : pick_value());
      send_item(REQ_LOAD_B, 6'(i), (i == 0) ? 16'h8000 : (i == 63) ? 16'h7FFF : pick_value(),
                (i == 0) ? 16'h8000 : (i == 63) ? 16'h7FFF : pick_value());
    end
    send_item(REQ_LOAD_B, 6'd63, 16'h8000, 16'h8000);
    send_item(REQ_NOP, 6'd63, 16'hFFFF, 16'hFFFF);
    send_item(REQ_FUSE, 6'd0, 16'h0, 16'h0);
    drain_results();

    directed_phase(2'd3, 2'd3, {6'd0, 6'd1, 6'd2}, {6'd2, 6'd1, 6'd0});
    directed_phase(2'd0, 2'd0, 18'h3FFFF, 18'h3FFFF);
    directed_phase(2'd3, 2'd3, {6'd2, 6'd1, 6'd0}, {6'd5, 6'd4, 6'd3});
    directed_phase(2'd2, 2'd1, {6'd0, 6'd63, 6'd63}, {6'd0, 6'd7, 6'd63});
    directed_phase(2'd3, 2'd0, 18'h3FFFF, 18'd0);
    directed_phase(2'd1, 2'd2, {6'd0, 6'd0, 6'd5}, {6'd0, 6'd63, 6'd0});
    directed_phase(2'd2, 2'd3, {6'd0, 6'd9, 6'd4}, {6'd4, 6'd4, 6'd4});

    for (int p = 0; p < 8; p++) begin
      calm = (p == 3 || p == 4);
      set_gates(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pick_ids(), pick_ids());
      for (int n = 0; n < 22; n++) begin
        random_item();
        if (p == 1 && n == 11) drain_results();
      end
      drain_results();
    end

    if (sb.fused_q.size() != 0) sb.errors++;
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/gmfc_pkg.sv
rtl/core/gmfc_front.sv
rtl/core/gmfc_back.sv
rtl/core/gate_matrix_fusion_contract_core.sv
tb/sv/gate_matrix_fusion_contract_core_tb.sv
